### design/mmdp_pkg.sv
// Shared widths, reset values and chain control type for the down-right pair difference search.
package mmdp_pkg;

   localparam int ELEM_W   = 32;
   localparam int RESULT_W = 33;
   localparam int CSR_W    = 6;

   // most negative result value, the start of every search
   localparam logic signed [RESULT_W-1:0] BEST_RESET = {1'b1, {(RESULT_W-1){1'b0}}};

   typedef logic signed [ELEM_W-1:0]   elem_type;
   typedef logic signed [RESULT_W-1:0] result_type;

   // control that travels from the sequencer to every cell of the row store
   typedef struct packed {
      logic     shift;
      elem_type tail_value;
   } chain_ctl_type;

endpackage

### design/mmdp_req_if.sv
// Input channel: one matrix element per word.
interface mmdp_req_if;
   logic                valid;
   logic                ready;
   mmdp_pkg::elem_type  element;

   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

### design/mmdp_rsp_if.sv
// Result channel: one greatest difference per matrix.
interface mmdp_rsp_if;
   logic                 valid;
   logic                 ready;
   mmdp_pkg::result_type max_difference;

   modport source (output valid, output max_difference, input ready);
   modport sink (input valid, input max_difference, output ready);
endinterface

### design/matrix_max_dominant_pair_difference.sv
// Top level: streaming greatest down-right pair difference over a square signed matrix.
//
// Usage:
//   req carries the matrix elements in row-major order, one word per element.
//   rsp carries one max_difference word per matrix, the greatest value of
//   mat[d][e] - mat[a][b] with d > a and e > b, exact in 33 bits.
//   csr_write_enable / csr_write_data set the side of the matrix (2 .. MAX_DIM,
//   smaller values act as 2, larger as MAX_DIM); a write restarts the matrix.
// Throughput: one element per cycle while the result slot is free for each last element.
//   Each element costs three compares, one 33-bit subtract and one row store chain shift.
// Latency: the result is registered and appears the cycle after the last
//   element of the matrix is accepted; the next matrix may start in that cycle.
// Row store: a chain of MAX_DIM cells shifting one place per element; the head
//   cell holds the minimum for the current column from the second row on; the
//   merged minimum enters at the cell at position dim-1.
// Reset: indices clear, side goes to 32 (or MAX_DIM if smaller), no clearing
//   pass is needed since the first row writes every column before it is read.
// Stall: while a result waits, elements other than a matrix's last are still
//   taken; the last element waits until the result slot is free.
module matrix_max_dominant_pair_difference #(
   parameter int MAX_DIM = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [mmdp_pkg::CSR_W-1:0]     csr_write_data,
   mmdp_req_if.sink                       req,
   mmdp_rsp_if.source                     rsp
);

   localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RESET_LAST = (MAX_DIM < 32) ? MAX_DIM - 1 : 31;

   logic [IDX_W-1:0]     last_ff, last_in;
   logic [IDX_W-1:0]     row_ff, row_in;
   logic [IDX_W-1:0]     col_ff, col_in;
   mmdp_pkg::elem_type   row_min_ff, row_min_in;
   mmdp_pkg::elem_type   diag_ff, diag_in;
   mmdp_pkg::result_type best_ff, best_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mmdp_pkg::result_type rsp_data_ff, rsp_data_in;

   mmdp_pkg::elem_type    cell_value [MAX_DIM];
   mmdp_pkg::chain_ctl_type chain_ctl;

   logic                 accept;
   logic                 first_row;
   logic                 final_word;
   mmdp_pkg::elem_type   x;
   mmdp_pkg::elem_type   head;
   mmdp_pkg::elem_type   store_new;
   mmdp_pkg::result_type diff;
   mmdp_pkg::result_type candidate;
   logic [31:0]          csr_wide;

   assign x          = req.element;
   assign head       = cell_value[0];
   assign first_row  = (row_ff == '0);
   assign final_word = (col_ff == last_ff) && (row_ff == last_ff);
   // only the last word of a matrix needs the result slot
   assign req.ready  = !rsp_valid_ff || rsp.ready || !final_word;
   assign accept     = req.valid && req.ready;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.max_difference = rsp_data_ff;

   always_comb begin
      csr_wide = {{(32-mmdp_pkg::CSR_W){1'b0}}, csr_write_data};
      if (csr_wide < 32'd2) begin
         last_in = IDX_W'(1);
      end else if (csr_wide > 32'(MAX_DIM)) begin
         last_in = IDX_W'(MAX_DIM - 1);
      end else begin
         last_in = IDX_W'(csr_wide - 32'd1);
      end
   end

   always_comb begin
      row_min_in = row_min_ff;
      diag_in    = diag_ff;
      best_in    = best_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      if (col_ff == '0 || x < row_min_ff) begin
         row_min_in = x;
      end
      if (first_row) begin
         store_new = row_min_in;
      end else begin
         store_new = (row_min_in < head) ? row_min_in : head;
      end
      diff = mmdp_pkg::result_type'(x) - mmdp_pkg::result_type'(diag_ff);
      candidate = best_ff;
      if (!first_row && col_ff != '0 && diff > best_ff) begin
         candidate = diff;
      end

      if (csr_write_enable) begin
         row_in  = '0;
         col_in  = '0;
         best_in = mmdp_pkg::BEST_RESET;
      end else if (accept) begin
         if (!first_row) begin
            diag_in = head;
         end
         best_in = candidate;
         if (col_ff == last_ff) begin
            col_in = '0;
            if (row_ff == last_ff) begin
               row_in       = '0;
               best_in      = mmdp_pkg::BEST_RESET;
               rsp_data_in  = candidate;
               rsp_valid_in = 1'b1;
            end else begin
               row_in = row_ff + IDX_W'(1);
            end
         end else begin
            col_in = col_ff + IDX_W'(1);
         end
      end else begin
         row_min_in = row_min_ff;
      end
   end

   always_comb begin
      chain_ctl.shift      = accept && !csr_write_enable;
      chain_ctl.tail_value = store_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= IDX_W'(RESET_LAST);
         row_ff       <= '0;
         col_ff       <= '0;
         best_ff      <= mmdp_pkg::BEST_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            last_ff <= last_in;
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_min_ff  <= row_min_in;
      diag_ff     <= diag_in;
      rsp_data_ff <= rsp_data_in;
   end

   for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
      mmdp_pkg::elem_type neighbour;
      if (i == MAX_DIM - 1) begin : g_end
         assign neighbour = store_new;
      end else begin : g_mid
         assign neighbour = cell_value[i+1];
      end
      mmdp_cell u_cell (
         .clock           (clock),
         .ctl             (chain_ctl),
         .is_tail         (last_ff == IDX_W'(i)),
         .neighbour_value (neighbour),
         .value           (cell_value[i])
      );
   end

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= last_ff) && (row_ff <= last_ff))
      else $error("matrix index beyond side");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (row_ff == '0) && (col_ff == '0))
      else $error("side write did not restart the matrix");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && final_word))
      else $error("result raised without a final word");

   a_stall_only_on_final: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp_valid_ff && final_word))
      else $error("input held off without a waiting result");

endmodule

### design/mmdp_cell.sv
// One cell of the row store: holds a column minimum and passes it towards the head.
module mmdp_cell (
   input  logic                    clock,
   input  mmdp_pkg::chain_ctl_type ctl,
   input  logic                    is_tail,
   input  mmdp_pkg::elem_type      neighbour_value,
   output mmdp_pkg::elem_type      value
);

   mmdp_pkg::elem_type value_ff;
   mmdp_pkg::elem_type value_in;

   // the tail cell takes the freshly merged minimum, the others take the next cell's word
   always_comb begin
      value_in = is_tail ? ctl.tail_value : neighbour_value;
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

### tb/sv/tb_matrix_max_dominant_pair_difference.sv
// Self-checking testbench for the streaming down-right pair difference search.
module tb_matrix_max_dominant_pair_difference;

   localparam int MAX_DIM       = 32;
   localparam int CSR_W         = mmdp_pkg::CSR_W;
   localparam int RANDOM_ITEMS  = 700;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;

   localparam mmdp_pkg::elem_type ELEM_MIN = 32'sh8000_0000;
   localparam mmdp_pkg::elem_type ELEM_MAX = 32'sh7fff_ffff;

   typedef enum logic {ROW_ELEMENT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      mmdp_pkg::elem_type   value;
      logic                 typed;
      mmdp_pkg::result_type want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_write_enable;
   logic [CSR_W-1:0]  csr_write_data;

   mmdp_req_if req_ch ();
   mmdp_rsp_if rsp_ch ();

   matrix_max_dominant_pair_difference #(.MAX_DIM(MAX_DIM)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   always #6 clock = ~clock;

   // directed stimulus: a partial matrix at the reset side, clamped sides,
   // extreme differences both ways, and a small matrix left to the predictor
   directed_row_type directed_rows [27] = '{
      '{ROW_ELEMENT, 32'sd5,    1'b0, '0},
      '{ROW_ELEMENT, -32'sd7,   1'b0, '0},
      '{ROW_ELEMENT, 32'sd100,  1'b0, '0},
      '{ROW_CSR,     32'sd0,    1'b0, '0},
      '{ROW_ELEMENT, ELEM_MIN,  1'b0, '0},
      '{ROW_ELEMENT, 32'sd0,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd0,    1'b0, '0},
      '{ROW_ELEMENT, ELEM_MAX,  1'b1, 33'sh0_ffff_ffff},
      '{ROW_ELEMENT, ELEM_MAX,  1'b0, '0},
      '{ROW_ELEMENT, ELEM_MIN,  1'b0, '0},
      '{ROW_ELEMENT, ELEM_MIN,  1'b0, '0},
      '{ROW_ELEMENT, ELEM_MIN,  1'b1, 33'sh1_0000_0001},
      '{ROW_CSR,     32'sd1,    1'b0, '0},
      '{ROW_ELEMENT, -32'sd1,   1'b0, '0},
      '{ROW_ELEMENT, ELEM_MAX,  1'b0, '0},
      '{ROW_ELEMENT, ELEM_MIN,  1'b0, '0},
      '{ROW_ELEMENT, -32'sd1,   1'b1, 33'sh0_0000_0000},
      '{ROW_CSR,     32'sd3,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd3,    1'b0, '0},
      '{ROW_ELEMENT, -32'sd1,   1'b0, '0},
      '{ROW_ELEMENT, 32'sd4,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd1,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd5,    1'b0, '0},
      '{ROW_ELEMENT, -32'sd9,   1'b0, '0},
      '{ROW_ELEMENT, 32'sd2,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd6,    1'b0, '0},
      '{ROW_ELEMENT, 32'sd5,    1'b0, '0}
   };

   // predictor state
   mmdp_pkg::elem_type   above_left_min [MAX_DIM];
   mmdp_pkg::elem_type   row_run_min;
   mmdp_pkg::elem_type   diag_min;
   mmdp_pkg::result_type best_diff;
   int                   at_row;
   int                   at_col;
   int                   side;

   mmdp_pkg::result_type pending_max_diff [$];

   bit src_steady;
   bit sink_steady;
   int elements_sent;
   int results_checked;
   int side_writes;
   int mismatches;

   function automatic int side_from(logic [CSR_W-1:0] code);
      if (code < 2) return 2;
      if (code > MAX_DIM) return MAX_DIM;
      return int'(code);
   endfunction

   function automatic int draw_gap(bit steady);
      return steady ? 0 : int'($urandom_range(0, 4));
   endfunction

   function automatic mmdp_pkg::elem_type draw_element();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return mmdp_pkg::elem_type'($urandom);
         4, 5, 6:    return mmdp_pkg::elem_type'(int'($urandom_range(0, 32)) - 16);
         7:          return ELEM_MIN;
         8:          return ELEM_MAX;
         default:    return $urandom_range(0, 1)
                        ? ELEM_MIN + mmdp_pkg::elem_type'($urandom_range(0, 3))
                        : ELEM_MAX - mmdp_pkg::elem_type'($urandom_range(0, 3));
      endcase
   endfunction

   task automatic restart_search();
      at_row    = 0;
      at_col    = 0;
      best_diff = mmdp_pkg::BEST_RESET;
   endtask

   // fold one element into the running search; finished marks the last of a matrix
   task automatic track_pair_difference(input mmdp_pkg::elem_type x, output bit finished,
                                        output mmdp_pkg::result_type best_out);
      mmdp_pkg::elem_type   above;
      mmdp_pkg::result_type diff;
      finished = 1'b0;
      best_out = '0;
      if (at_col == 0 || x < row_run_min) row_run_min = x;
      if (at_row == 0) begin
         above_left_min[at_col] = row_run_min;
      end else begin
         above = above_left_min[at_col];
         if (at_col != 0) begin
            diff = mmdp_pkg::result_type'(x) - mmdp_pkg::result_type'(diag_min);
            if (diff > best_diff) best_diff = diff;
         end
         diag_min = above;
         above_left_min[at_col] = (row_run_min < above) ? row_run_min : above;
      end
      if (at_col + 1 < side) begin
         at_col++;
      end else begin
         at_col = 0;
         if (at_row + 1 < side) begin
            at_row++;
         end else begin
            finished = 1'b1;
            best_out = best_diff;
            restart_search();
         end
      end
   endtask

   // offer one word, hold it until taken, then queue what it produces
   task automatic send_element(input mmdp_pkg::elem_type value, input bit typed,
                               input mmdp_pkg::result_type want);
      int                   gap;
      bit                   finished;
      mmdp_pkg::result_type predicted;
      gap = draw_gap(src_steady);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.element <= value;
      do @(posedge clock); while (!req_ch.ready);
      track_pair_difference(value, finished, predicted);
      if (finished) begin
         pending_max_diff.push_back(typed ? want : predicted);
      end else if (typed) begin
         $display("%0t: table row expects max_difference %0d, predictor gives none",
                  $time, want);
         mismatches++;
      end
      elements_sent++;
      @(negedge clock);
   endtask

   // write the side only once the block has drained
   task automatic write_side(input logic [CSR_W-1:0] code);
      req_ch.valid <= 1'b0;
      while (pending_max_diff.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= code;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      side = side_from(code);
      restart_search();
      side_writes++;
   endtask

   // result side: random back-pressure, compare each word with the oldest expectation
   initial begin : result_check
      int                   stall;
      mmdp_pkg::result_type want;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_gap(sink_steady);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         if (pending_max_diff.size() == 0) begin
            $display("%0t: unexpected max_difference, expected none, got %0d",
                     $time, rsp_ch.max_difference);
            mismatches++;
         end else begin
            want = pending_max_diff.pop_front();
            if (rsp_ch.max_difference !== want) begin
               $display("%0t: max_difference mismatch, expected %0d, got %0d",
                        $time, want, rsp_ch.max_difference);
               mismatches++;
            end
            results_checked++;
         end
         @(negedge clock);
      end
   end

   // count cycles and stop a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t: cycle limit reached", $time);
      $display("** matrix_max_dominant_pair_difference: FAILED **");
      $finish;
   end

   initial begin : stimulus
      logic [CSR_W-1:0] code;
      int               matrices;
      int               n;
      int               random_items;
      bit               big_done;
      bit               big_now;

      req_ch.valid     = 1'b0;
      req_ch.element   = '0;
      rsp_ch.ready     = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      foreach (above_left_min[i]) above_left_min[i] = '0;
      row_run_min = '0;
      diag_min    = '0;
      side        = side_from(CSR_W'(MAX_DIM));
      restart_search();
      random_items = 0;
      big_done     = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR)
            write_side(directed_rows[i].value[CSR_W-1:0]);
         else
            send_element(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end

      // mostly whole matrices at small sides; one larger matrix halfway through
      while (random_items < RANDOM_ITEMS || !big_done) begin
         big_now = !big_done && random_items >= RANDOM_ITEMS / 2;
         if (big_now) begin
            code     = CSR_W'($urandom_range(12, 16));
            matrices = 1;
            big_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0:       code = CSR_W'($urandom_range(0, 1));
               1:       code = CSR_W'($urandom_range(6, 10));
               default: code = CSR_W'($urandom_range(2, 5));
            endcase
            matrices = $urandom_range(1, 4);
         end
         write_side(code);
         src_steady  = ($urandom_range(0, 3) == 0);
         sink_steady = ($urandom_range(0, 3) == 0);
         n = side * side;
         repeat (matrices * n) begin
            send_element(draw_element(), 1'b0, '0);
            random_items++;
         end
         // drop a matrix part way through; the next side write abandons it
         if (!big_now && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, n - 1)) begin
               send_element(draw_element(), 1'b0, '0);
               random_items++;
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_max_diff.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d elements over %0d side settings, clamped codes and a larger side included",
               elements_sent, side_writes);
      $display("Checked %0d max_difference words, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("** matrix_max_dominant_pair_difference: PASSED **");
      end else begin
         $display("** matrix_max_dominant_pair_difference: FAILED **");
      end
      $finish;
   end

endmodule

### filelist.f
design/mmdp_pkg.sv
design/mmdp_req_if.sv
design/mmdp_rsp_if.sv
design/mmdp_cell.sv
design/matrix_max_dominant_pair_difference.sv
tb/sv/tb_matrix_max_dominant_pair_difference.sv
